FILE: hw/rtl/hq_pkg.sv
package hq_pkg;

  localparam int unsigned InWidth      = 32;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned HalfWidth    = 15;
  localparam int unsigned DecodedWidth = 31;

  localparam logic [StatusWidth-1:0] StatusOk       = 2'd0;
  localparam logic [StatusWidth-1:0] StatusNotFinite = 2'd1;
  localparam logic [StatusWidth-1:0] StatusRange    = 2'd2;
  localparam logic [StatusWidth-1:0] StatusOverflow = 2'd3;

  localparam logic [7:0]  ExpAllOnes    = 8'hff;
  localparam logic [7:0]  ExpHalfMin    = 8'd113;  // binary32 exponent of 2^-14
  localparam logic [7:0]  ExpBiasDelta  = 8'd112;  // 127 - 15
  localparam logic [7:0]  SubShiftBase  = 8'd126;  // 13 + 113
  localparam logic [30:0] MaxFiniteBits = 31'h477fe000;
  localparam logic [4:0]  HalfExpMax    = 5'h1f;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [HalfWidth-1:0]   half_bits;
  } hq_enc_t;

endpackage

FILE: hw/rtl/float32_to_half_quantizer.sv
// Pipeline: an accepted input is held in the input register, encoded and
// decoded, and registered in the result register that drives out_valid_o.
// Throughput: one transaction per cycle while out_stall_i is low, set by the
// input register feeding the encode/decode logic and the result register.
// Reset: asynchronous, active low; clears both valid flags, so the block
// comes out of reset empty and ready.
module float32_to_half_quantizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [hq_pkg::InWidth-1:0]       value_bits_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [hq_pkg::StatusWidth-1:0]   status_o,
  output logic [hq_pkg::HalfWidth-1:0]     half_bits_o,
  output logic [hq_pkg::DecodedWidth-1:0]  decoded_bits_o
);

  logic                              in_vld_q;
  logic [hq_pkg::InWidth-1:0]        in_data_q;
  logic                              out_vld_q;
  logic [hq_pkg::StatusWidth-1:0]    status_q;
  logic [hq_pkg::HalfWidth-1:0]      half_q;
  logic [hq_pkg::DecodedWidth-1:0]   dec_q;

  hq_pkg::hq_enc_t                   enc;
  logic [hq_pkg::DecodedWidth-1:0]   dec;
  logic                              out_load;
  logic                              in_load;

  hq_encode u_encode (
    .value_bits_i (in_data_q),
    .enc_o        (enc)
  );

  hq_decode u_decode (
    .half_bits_i    (enc.half_bits),
    .decoded_bits_o (dec)
  );

  assign out_load   = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_load) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_data_q <= value_bits_i;
    end
    if (out_load && in_vld_q) begin
      status_q <= enc.status;
      half_q   <= (enc.status == hq_pkg::StatusOk) ? enc.half_bits : '0;
      dec_q    <= (enc.status == hq_pkg::StatusOk) ? dec : '0;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign half_bits_o    = half_q;
  assign decoded_bits_o = dec_q;

endmodule

FILE: hw/rtl/hq_encode.sv
module hq_encode (
  input  logic [hq_pkg::InWidth-1:0] value_bits_i,
  output hq_pkg::hq_enc_t            enc_o
);

  logic        sign;
  logic [30:0] mag;
  logic [7:0]  expo;
  logic [22:0] man;

  logic [10:0] norm_hm;
  logic        norm_up;
  logic [8:0]  norm_he;
  logic [14:0] norm_h;
  logic        norm_ovf;

  logic [7:0]  sub_sh;
  logic [4:0]  sub_sh5;
  logic [31:0] sub_v;
  logic [31:0] sub_q;
  logic [31:0] sub_rem;
  logic [31:0] sub_half;
  logic [31:0] sub_r;
  logic [14:0] sub_h;

  assign sign = value_bits_i[31];
  assign mag  = value_bits_i[30:0];
  assign expo = value_bits_i[30:23];
  assign man  = value_bits_i[22:0];

  // normal half range: round mantissa by 13 to nearest even
  assign norm_up = (man[12:0] > 13'h1000) || ((man[12:0] == 13'h1000) && man[13]);
  assign norm_hm = {1'b0, man[22:13]} + {10'd0, norm_up};
  assign norm_he = {1'b0, expo - hq_pkg::ExpBiasDelta} + {8'd0, norm_hm[10]};
  assign norm_ovf = (norm_he >= {4'd0, hq_pkg::HalfExpMax});
  assign norm_h  = {norm_he[4:0], norm_hm[9:0]};

  // half subnormal range: rounding right shift of the full significand
  assign sub_sh   = hq_pkg::SubShiftBase - expo;
  assign sub_sh5  = sub_sh[4:0];
  assign sub_v    = {8'd0, 1'b1, man};
  assign sub_q    = sub_v >> sub_sh5;
  assign sub_rem  = sub_v & ((32'd1 << sub_sh5) - 32'd1);
  assign sub_half = 32'd1 << (sub_sh5 - 5'd1);
  assign sub_r    = sub_q + {31'd0, (sub_rem > sub_half) ||
                                    ((sub_rem == sub_half) && sub_q[0])};
  assign sub_h    = (sub_sh >= 8'd32) ? 15'd0 : sub_r[14:0];

  always_comb begin
    enc_o.status    = hq_pkg::StatusOk;
    enc_o.half_bits = '0;
    if (expo == hq_pkg::ExpAllOnes) begin
      enc_o.status = hq_pkg::StatusNotFinite;
    end else if ((sign && (mag != '0)) || (mag > hq_pkg::MaxFiniteBits)) begin
      enc_o.status = hq_pkg::StatusRange;
    end else if (expo == 8'd0) begin
      enc_o.half_bits = '0;
    end else if (expo >= hq_pkg::ExpHalfMin) begin
      if (norm_ovf) begin
        enc_o.status = hq_pkg::StatusOverflow;
      end else begin
        enc_o.half_bits = norm_h;
      end
    end else begin
      enc_o.half_bits = sub_h;
    end
  end

endmodule

FILE: hw/rtl/hq_decode.sv
module hq_decode (
  input  logic [hq_pkg::HalfWidth-1:0]    half_bits_i,
  output logic [hq_pkg::DecodedWidth-1:0] decoded_bits_o
);

  logic [4:0] e;
  logic [9:0] m;
  logic [3:0] lead;
  logic [3:0] shift;
  logic [9:0] m_norm;
  logic [7:0] sub_exp;

  assign e = half_bits_i[14:10];
  assign m = half_bits_i[9:0];

  // position of the leading one in the subnormal mantissa
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        lead = 4'(i);
      end
    end
  end

  assign shift   = 4'd10 - lead;
  assign m_norm  = 10'(m << shift);
  assign sub_exp = hq_pkg::ExpHalfMin - {4'd0, shift};

  always_comb begin
    if (e != 5'd0) begin
      decoded_bits_o = {{3'd0, e} + hq_pkg::ExpBiasDelta, m, 13'd0};
    end else if (m == 10'd0) begin
      decoded_bits_o = '0;
    end else begin
      decoded_bits_o = {sub_exp, m_norm, 13'd0};
    end
  end

endmodule
